// ===== src/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and helpers for the JSON string unescaper
// Phase codes, result item layout, escape/hex decode and the UTF-8 encoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

	localparam int unsigned RES_MAX = 6;	// most result items one input item can cause
	localparam int unsigned CNT_W   = 3;

	localparam logic [7:0]  CH_QUOTE = 8'h22;
	localparam logic [7:0]  CH_BSL   = 8'h5C;
	localparam logic [7:0]  CH_U     = 8'h75;
	localparam logic [20:0] CP_REPL  = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP  = 21'h010000;
	localparam logic [5:0]  SUR_HIGH = 6'b110110;	// D800..DBFF >> 10
	localparam logic [5:0]  SUR_LOW  = 6'b110111;	// DC00..DFFF >> 10

	typedef enum logic [6:0] {
		PH_IDLE    = 7'b0000001,
		PH_BODY    = 7'b0000010,
		PH_ESC     = 7'b0000100,
		PH_HEX     = 7'b0001000,
		PH_HIGH    = 7'b0010000,
		PH_HIGH_BS = 7'b0100000,
		PH_LOW_HEX = 7'b1000000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CAUSE_NONE     = 3'd0,
		CAUSE_NO_QUOTE = 3'd1,
		CAUSE_BAD_ESC  = 3'd2,
		CAUSE_BAD_HEX  = 3'd3,
		CAUSE_TRUNC    = 3'd4
	} cause_t;

	typedef enum logic [1:0] {
		TAIL_NONE   = 2'd0,
		TAIL_SINGLE = 2'd1,
		TAIL_CP     = 2'd2
	} tail_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		cause_t     cause;
	} res_t;

	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] ch;
	} esc_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hexd_t;

	function automatic esc_t simple_esc(input logic [7:0] c);
		esc_t r;
		r.ok = 1'b1;
		r.ch = c;
		case (c)
			8'h22, 8'h5C, 8'h2F: r.ch = c;
			8'h62: r.ch = 8'h08;	// b
			8'h66: r.ch = 8'h0C;	// f
			8'h6E: r.ch = 8'h0A;	// n
			8'h72: r.ch = 8'h0D;	// r
			8'h74: r.ch = 8'h09;	// t
			default: begin
				r.ok = 1'b0;
				r.ch = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic hexd_t hex_digit(input logic [7:0] c);
		hexd_t r;
		r.ok  = 1'b1;
		r.val = 4'h0;
		if (c >= 8'h30 && c <= 8'h39)
			r.val = c[3:0];
		else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			r.val = c[3:0] + 4'd9;
		else
			r.ok = 1'b0;
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.b[0] = cp[7:0];
			r.n    = 3'd1;
		end else if (cp < 21'h800) begin
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
			r.n    = 3'd2;
		end else if (cp < 21'h10000) begin
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
			r.n    = 3'd3;
		end else begin
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
			r.n    = 3'd4;
		end
		return r;
	endfunction

endpackage

// ===== src/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes one JSON string literal, byte by byte, into UTF-8 bytes, an end
// marker on the closing quote, or a single error item.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser   tlast
//  s_axis    in   [7:0] in_byte                          -       in_end
//  m_axis    out  [7:0] out_byte, [10:8] err_cause, 0s   kind    last
//
// Each accepted byte is decoded in the cycle it is taken; its 0..6 result items
// are loaded into a 6-entry result register and leave one per cycle while the
// receiver is ready. A byte giving more than one item holds off the next input
// byte until the result register has drained to its last item.
// s_axis_tready is high while no item is left, or the last one is being taken.
// arst_n clears phase and the result count; the first byte must be a quote.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,	// [7:0] in_byte
	input  logic        s_axis_tlast,	// in_end
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,	// [7:0] out_byte, [10:8] err_cause
	output logic [1:0]  m_axis_tuser,	// [1:0] kind
	output logic        m_axis_tlast	// last
);

	jsu_pkg::phase_t phase_q, ph_d;
	logic [15:0] hex_q, hv_d;
	logic [1:0]  hc_q, hc_d;
	logic [9:0]  pend_q, pend_d;

	jsu_pkg::res_t             res_q [jsu_pkg::RES_MAX];
	jsu_pkg::res_t             new_res [jsu_pkg::RES_MAX];
	logic [jsu_pkg::CNT_W-1:0] cnt_q, new_n;

	jsu_pkg::cause_t err;
	jsu_pkg::tail_t  tail_mode;
	jsu_pkg::res_t   tail_item;
	jsu_pkg::res_t   tl [4];
	logic [2:0]      tail_n;
	logic [20:0]     tail_cp;
	logic            pre;
	logic [15:0]     nv;
	logic            nv_high, nv_low;
	jsu_pkg::esc_t   esc;
	jsu_pkg::hexd_t  hd;
	jsu_pkg::utf8_t  enc, repl;
	logic            acc, take;
	logic [7:0]      b;

	assign b    = s_axis_tdata;
	assign acc  = s_axis_tvalid & s_axis_tready;
	assign take = m_axis_tvalid & m_axis_tready;
	assign s_axis_tready = (cnt_q == '0) || (cnt_q == 3'd1 && m_axis_tready);

	assign esc     = jsu_pkg::simple_esc(b);
	assign hd      = jsu_pkg::hex_digit(b);
	assign nv      = {hex_q[11:0], hd.val};
	assign nv_high = (nv[15:10] == jsu_pkg::SUR_HIGH);
	assign nv_low  = (nv[15:10] == jsu_pkg::SUR_LOW);
	assign repl    = jsu_pkg::utf8_enc(jsu_pkg::CP_REPL);
	assign enc     = jsu_pkg::utf8_enc(tail_cp);

	// next state and what the byte produces: optional U+FFFD prefix, then a tail, or an error cause
	always_comb begin
		ph_d      = phase_q;
		hv_d      = hex_q;
		hc_d      = hc_q;
		pend_d    = pend_q;
		err       = jsu_pkg::CAUSE_NONE;
		pre       = 1'b0;
		tail_mode = jsu_pkg::TAIL_NONE;
		tail_item = '{data: b, kind: jsu_pkg::KIND_DATA, cause: jsu_pkg::CAUSE_NONE};
		tail_cp   = '0;
		unique case (phase_q) inside
			jsu_pkg::PH_BODY: begin
				if (b == jsu_pkg::CH_QUOTE) begin
					tail_mode = jsu_pkg::TAIL_SINGLE;
					tail_item = '{data: 8'h00, kind: jsu_pkg::KIND_END,
						cause: jsu_pkg::CAUSE_NONE};
					ph_d = jsu_pkg::PH_IDLE;
				end else if (b == jsu_pkg::CH_BSL) begin
					ph_d = jsu_pkg::PH_ESC;
				end else begin
					tail_mode = jsu_pkg::TAIL_SINGLE;
				end
			end
			jsu_pkg::PH_ESC: begin
				if (b == jsu_pkg::CH_U) begin
					hv_d = '0;
					hc_d = '0;
					ph_d = jsu_pkg::PH_HEX;
				end else if (esc.ok) begin
					tail_mode      = jsu_pkg::TAIL_SINGLE;
					tail_item.data = esc.ch;
					ph_d           = jsu_pkg::PH_BODY;
				end else begin
					err = jsu_pkg::CAUSE_BAD_ESC;
				end
			end
			jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
				if (!hd.ok) begin
					err = jsu_pkg::CAUSE_BAD_HEX;
				end else if (hc_q != 2'd3) begin
					hc_d = hc_q + 2'd1;
					hv_d = nv;
				end else begin
					hc_d = '0;
					hv_d = nv;
					if (phase_q == jsu_pkg::PH_LOW_HEX && nv_low) begin
						tail_mode = jsu_pkg::TAIL_CP;
						tail_cp   = jsu_pkg::CP_SUPP + {1'b0, pend_q, nv[9:0]};
						pend_d    = '0;
						ph_d      = jsu_pkg::PH_BODY;
					end else begin
						// held high surrogate went unpaired
						if (phase_q == jsu_pkg::PH_LOW_HEX) begin
							pre    = 1'b1;
							pend_d = '0;
						end
						if (nv_high) begin
							pend_d = nv[9:0];
							ph_d   = jsu_pkg::PH_HIGH;
						end else begin
							tail_mode = jsu_pkg::TAIL_CP;
							tail_cp   = nv_low ? jsu_pkg::CP_REPL : {5'b0, nv};
							ph_d      = jsu_pkg::PH_BODY;
						end
					end
				end
			end
			jsu_pkg::PH_HIGH: begin
				if (b == jsu_pkg::CH_BSL) begin
					ph_d = jsu_pkg::PH_HIGH_BS;
				end else begin
					pre       = 1'b1;
					pend_d    = '0;
					tail_mode = jsu_pkg::TAIL_SINGLE;
					if (b == jsu_pkg::CH_QUOTE) begin
						tail_item = '{data: 8'h00, kind: jsu_pkg::KIND_END,
							cause: jsu_pkg::CAUSE_NONE};
						ph_d = jsu_pkg::PH_IDLE;
					end else begin
						ph_d = jsu_pkg::PH_BODY;
					end
				end
			end
			jsu_pkg::PH_HIGH_BS: begin
				if (b == jsu_pkg::CH_U) begin
					hv_d = '0;
					hc_d = '0;
					ph_d = jsu_pkg::PH_LOW_HEX;
				end else if (esc.ok) begin
					pre            = 1'b1;
					pend_d         = '0;
					tail_mode      = jsu_pkg::TAIL_SINGLE;
					tail_item.data = esc.ch;
					ph_d           = jsu_pkg::PH_BODY;
				end else begin
					err = jsu_pkg::CAUSE_BAD_ESC;
				end
			end
			default: begin
				// waiting for the opening quote; stray codes land here too
				if (b == jsu_pkg::CH_QUOTE)
					ph_d = jsu_pkg::PH_BODY;
				else
					err = jsu_pkg::CAUSE_NO_QUOTE;
			end
		endcase

		if (err == jsu_pkg::CAUSE_NONE && s_axis_tlast && ph_d != jsu_pkg::PH_IDLE)
			err = jsu_pkg::CAUSE_TRUNC;
		if (err != jsu_pkg::CAUSE_NONE) begin
			ph_d   = jsu_pkg::PH_IDLE;
			hv_d   = '0;
			hc_d   = '0;
			pend_d = '0;
		end
	end

	// assemble the result list
	always_comb begin
		for (int i = 0; i < 4; i++)
			tl[i] = '0;
		tail_n = '0;
		if (tail_mode == jsu_pkg::TAIL_SINGLE) begin
			tl[0]  = tail_item;
			tail_n = 3'd1;
		end else if (tail_mode == jsu_pkg::TAIL_CP) begin
			for (int i = 0; i < 4; i++)
				tl[i] = '{data: enc.b[i], kind: jsu_pkg::KIND_DATA,
					cause: jsu_pkg::CAUSE_NONE};
			tail_n = enc.n;
		end

		for (int j = 0; j < jsu_pkg::RES_MAX; j++)
			new_res[j] = '0;
		if (err != jsu_pkg::CAUSE_NONE) begin
			new_res[0] = '{data: 8'h00, kind: jsu_pkg::KIND_ERR, cause: err};
			new_n      = 3'd1;
		end else if (pre) begin
			for (int j = 0; j < 3; j++)
				new_res[j] = '{data: repl.b[j], kind: jsu_pkg::KIND_DATA,
					cause: jsu_pkg::CAUSE_NONE};
			new_res[3] = tl[0];
			new_res[4] = tl[1];
			new_res[5] = tl[2];
			new_n      = 3'd3 + tail_n;
		end else begin
			for (int j = 0; j < 4; j++)
				new_res[j] = tl[j];
			new_n = tail_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_IDLE;
			hex_q   <= '0;
			hc_q    <= '0;
			pend_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (acc) begin
				phase_q <= ph_d;
				hex_q   <= hv_d;
				hc_q    <= hc_d;
				pend_q  <= pend_d;
				cnt_q   <= new_n;
			end else if (take) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	// result register: load on accept, shift toward slot 0 as items leave
	always_ff @(posedge clk) begin
		if (acc) begin
			for (int j = 0; j < jsu_pkg::RES_MAX; j++)
				res_q[j] <= new_res[j];
		end else if (take) begin
			for (int j = 0; j < jsu_pkg::RES_MAX - 1; j++)
				res_q[j] <= res_q[j+1];
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {5'b0, res_q[0].cause, res_q[0].data};
	assign m_axis_tuser  = res_q[0].kind;
	assign m_axis_tlast  = (cnt_q == 3'd1);

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd6)
		else $error("result count out of range");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> (cnt_q <= 3'd1))
		else $error("input taken while results still queued");

	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == jsu_pkg::KIND_ERR) |-> m_axis_tlast)
		else $error("error item not the only item of its byte");

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && err != jsu_pkg::CAUSE_NONE) |=>
			(phase_q == jsu_pkg::PH_IDLE && pend_q == '0 && hc_q == '0))
		else $error("state not cleared after error");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != jsu_pkg::KIND_DATA) |->
			(m_axis_tdata[7:0] == 8'h00))
		else $error("end or error item carries a data byte");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: JSON string unescaper
// Streams JSON string literals (directed corner cases, then random strings
// with broken and cut-off ones mixed in) into the block under sender gaps
// and receiver stalls. Every decoded byte, end marker and error item is
// compared with the output of a cycle-free decoder kept in step with the
// accepted input bytes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic [7:0]      data;
		jsu_pkg::kind_t  kind;
		jsu_pkg::cause_t cause;
		logic            last;
	} out_item_t;

	typedef logic [7:0] text_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;	// [7:0] in_byte
	logic        s_axis_tlast = 1'b0;	// in_end
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;	// [7:0] out_byte, [10:8] err_cause
	logic [1:0]  m_axis_tuser;	// [1:0] kind
	logic        m_axis_tlast;	// last

	// decoder state, updated once per accepted item
	jsu_pkg::phase_t ph;
	logic [15:0]     esc_unit;
	logic [1:0]      digits;
	logic [9:0]      high_bits;

	out_item_t   decoded_q[$];	// items still to come out of the block
	out_item_t   step_q[$];	// items caused by the current input byte
	out_item_t   head_item;
	text_t       text_q;

	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int n_sent = 0;
	int n_errors = 0;
	int n_cycles = 0;

	json_string_unescape_utf8 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items outstanding", n_cycles,
				decoded_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic report(input string msg);
		n_errors++;
		if (n_errors <= 40)
			$display("mismatch at cycle %0d: %s", n_cycles, msg);
	endtask

	// ------------------------------------------------------------------
	// decoder
	// ------------------------------------------------------------------
	function automatic void reset_decoder();
		ph = jsu_pkg::PH_IDLE;
		esc_unit = '0;
		digits = '0;
		high_bits = '0;
	endfunction

	function automatic void clear_high();
		high_bits = '0;
	endfunction

	function automatic void add_item(input logic [7:0] d, input jsu_pkg::kind_t k);
		step_q.insert(step_q.size(),
			'{data: d, kind: k, cause: jsu_pkg::CAUSE_NONE, last: 1'b0});
	endfunction

	function automatic void add_cp(input logic [20:0] cp);
		int n;
		logic [7:0] lead;
		if (cp < 21'h80) begin
			add_item(cp[7:0], jsu_pkg::KIND_DATA);
			return;
		end
		n = (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
		lead = (n == 2) ? 8'hC0 : (n == 3) ? 8'hE0 : 8'hF0;
		add_item(lead | 8'(cp >> (6 * (n - 1))), jsu_pkg::KIND_DATA);
		for (int i = n - 2; i >= 0; i--)
			add_item(8'h80 | (8'(cp >> (6 * i)) & 8'h3F), jsu_pkg::KIND_DATA);
	endfunction

	// {valid, character} for the letter after a backslash; \u excluded
	function automatic logic [8:0] escape_map(input logic [7:0] c);
		case (c)
			jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, "/": return {1'b1, c};
			"b": return {1'b1, 8'h08};
			"f": return {1'b1, 8'h0C};
			"n": return {1'b1, 8'h0A};
			"r": return {1'b1, 8'h0D};
			"t": return {1'b1, 8'h09};
			default: return 9'h000;
		endcase
	endfunction

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c - "0";
		if (c >= "a" && c <= "f")
			return c - "a" + 10;
		if (c >= "A" && c <= "F")
			return c - "A" + 10;
		return -1;
	endfunction

	// a finished \u value: high surrogates wait for their partner
	function automatic void take_unit(input logic [15:0] v);
		if (v[15:10] == jsu_pkg::SUR_HIGH) begin
			high_bits = v[9:0];
			ph = jsu_pkg::PH_HIGH;
			return;
		end
		if (v[15:10] == jsu_pkg::SUR_LOW)
			add_cp(jsu_pkg::CP_REPL);
		else
			add_cp({5'd0, v});
		ph = jsu_pkg::PH_BODY;
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic fin);
		jsu_pkg::cause_t err;
		int d;
		logic [8:0] m;
		err = jsu_pkg::CAUSE_NONE;
		m = escape_map(b);
		step_q.delete();
		case (ph)
			jsu_pkg::PH_BODY: begin
				if (b == jsu_pkg::CH_QUOTE) begin
					add_item(8'h00, jsu_pkg::KIND_END);
					ph = jsu_pkg::PH_IDLE;
				end else if (b == jsu_pkg::CH_BSL) begin
					ph = jsu_pkg::PH_ESC;
				end else begin
					add_item(b, jsu_pkg::KIND_DATA);
				end
			end
			jsu_pkg::PH_ESC: begin
				if (b == jsu_pkg::CH_U) begin
					esc_unit = '0;
					digits = '0;
					ph = jsu_pkg::PH_HEX;
				end else if (m[8]) begin
					add_item(m[7:0], jsu_pkg::KIND_DATA);
					ph = jsu_pkg::PH_BODY;
				end else begin
					err = jsu_pkg::CAUSE_BAD_ESC;
				end
			end
			jsu_pkg::PH_HEX, jsu_pkg::PH_LOW_HEX: begin
				d = hex_nibble(b);
				if (d < 0) begin
					err = jsu_pkg::CAUSE_BAD_HEX;
				end else begin
					esc_unit = {esc_unit[11:0], d[3:0]};
					if (digits != 2'd3) begin
						digits++;
					end else begin
						digits = '0;
						if (ph == jsu_pkg::PH_HEX) begin
							take_unit(esc_unit);
						end else if (esc_unit[15:10] == jsu_pkg::SUR_LOW) begin
							add_cp(jsu_pkg::CP_SUPP + {1'b0, high_bits, esc_unit[9:0]});
							clear_high();
							ph = jsu_pkg::PH_BODY;
						end else begin
							add_cp(jsu_pkg::CP_REPL);
							clear_high();
							take_unit(esc_unit);
						end
					end
				end
			end
			jsu_pkg::PH_HIGH: begin
				if (b == jsu_pkg::CH_BSL) begin
					ph = jsu_pkg::PH_HIGH_BS;
				end else begin
					add_cp(jsu_pkg::CP_REPL);
					clear_high();
					if (b == jsu_pkg::CH_QUOTE) begin
						add_item(8'h00, jsu_pkg::KIND_END);
						ph = jsu_pkg::PH_IDLE;
					end else begin
						add_item(b, jsu_pkg::KIND_DATA);
						ph = jsu_pkg::PH_BODY;
					end
				end
			end
			jsu_pkg::PH_HIGH_BS: begin
				if (b == jsu_pkg::CH_U) begin
					esc_unit = '0;
					digits = '0;
					ph = jsu_pkg::PH_LOW_HEX;
				end else if (m[8]) begin
					add_cp(jsu_pkg::CP_REPL);
					add_item(m[7:0], jsu_pkg::KIND_DATA);
					clear_high();
					ph = jsu_pkg::PH_BODY;
				end else begin
					err = jsu_pkg::CAUSE_BAD_ESC;
				end
			end
			default: begin
				if (b == jsu_pkg::CH_QUOTE)
					ph = jsu_pkg::PH_BODY;
				else
					err = jsu_pkg::CAUSE_NO_QUOTE;
			end
		endcase

		// an error in this byte wins over running out of input
		if (err == jsu_pkg::CAUSE_NONE && fin && ph != jsu_pkg::PH_IDLE)
			err = jsu_pkg::CAUSE_TRUNC;
		if (err != jsu_pkg::CAUSE_NONE) begin
			step_q.delete();
			step_q.insert(0, '{data: 8'h00, kind: jsu_pkg::KIND_ERR, cause: err,
				last: 1'b0});
			reset_decoder();
		end
		if (step_q.size() != 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			decoded_q.insert(decoded_q.size(), step_q[i]);
	endfunction

	// ------------------------------------------------------------------
	// result checking and receiver stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				report($sformatf("unexpected item tdata %h tuser %0d", m_axis_tdata,
					m_axis_tuser));
			end else begin
				head_item = decoded_q.pop_front();
				if (m_axis_tdata[7:0] !== head_item.data)
					report($sformatf("out_byte %h, want %h", m_axis_tdata[7:0],
						head_item.data));
				if (m_axis_tdata[10:8] !== head_item.cause)
					report($sformatf("err_cause %0d, want %0d", m_axis_tdata[10:8],
						head_item.cause));
				if (m_axis_tdata[15:11] !== 5'd0)
					report($sformatf("tdata pad bits %b not zero", m_axis_tdata[15:11]));
				if (m_axis_tuser !== head_item.kind)
					report($sformatf("kind %0d, want %0d", m_axis_tuser, head_item.kind));
				if (m_axis_tlast !== head_item.last)
					report($sformatf("last %b, want %b", m_axis_tlast, head_item.last));
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// ------------------------------------------------------------------
	// sending
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= fin;
		do
			@(posedge clk);
		while (!s_axis_tready);
		decode_byte(b, fin);
		n_sent++;
	endtask

	// sends text_q[0..stop]; in_end, if fin is set, goes with the last one sent
	task automatic send_text(input int stop, input logic fin);
		for (int i = 0; i <= stop; i++)
			send_byte(text_q[i], (i == stop) ? fin : 1'b0);
	endtask

	task automatic send_str(input string s, input logic fin);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.insert(text_q.size(), s[i]);
		send_text(text_q.size() - 1, fin);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (jsu_pkg::RES_MAX + 4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// random text
	// ------------------------------------------------------------------
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10)
			return 8'("0" + n);
		return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
	endfunction

	function automatic void put_u(input logic [15:0] v);
		text_q.insert(text_q.size(), jsu_pkg::CH_BSL);
		text_q.insert(text_q.size(), jsu_pkg::CH_U);
		for (int i = 3; i >= 0; i--)
			text_q.insert(text_q.size(), hex_char(v[i * 4 +: 4]));
	endfunction

	function automatic logic [15:0] pick_unit();
		case ($urandom_range(6))
			0: return 16'($urandom_range('h7F));
			1: return 16'($urandom_range('h7FF, 'h80));
			2: begin
				if ($urandom_range(1))
					return 16'($urandom_range('hD7FF, 'h800));
				return 16'($urandom_range('hFFFF, 'hE000));
			end
			3, 4: return 16'($urandom_range('hDBFF, 'hD800));
			5: return 16'($urandom_range('hDFFF, 'hDC00));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] escape_letter(input int idx);
		case (idx)
			0: return jsu_pkg::CH_QUOTE;
			1: return jsu_pkg::CH_BSL;
			2: return "/";
			3: return "b";
			4: return "f";
			5: return "n";
			6: return "r";
			default: return "t";
		endcase
	endfunction

	// one string literal; a bad escape or bad hex digit ends it early
	function automatic void build_string();
		logic [15:0] v;
		logic [7:0] c;
		logic [8:0] m;
		int n_tok;
		text_q.delete();
		text_q.insert(text_q.size(), jsu_pkg::CH_QUOTE);
		n_tok = $urandom_range(5, 1);
		for (int k = 0; k < n_tok; k++) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5: begin
					do
						c = 8'($urandom);
					while (c == jsu_pkg::CH_QUOTE || c == jsu_pkg::CH_BSL);
					text_q.insert(text_q.size(), c);
				end
				6, 7, 8: begin
					text_q.insert(text_q.size(), jsu_pkg::CH_BSL);
					text_q.insert(text_q.size(), escape_letter($urandom_range(7)));
				end
				18: begin
					do begin
						c = 8'($urandom);
						m = escape_map(c);
					end while (m[8] || c == jsu_pkg::CH_U);
					text_q.insert(text_q.size(), jsu_pkg::CH_BSL);
					text_q.insert(text_q.size(), c);
					return;
				end
				19: begin
					text_q.insert(text_q.size(), jsu_pkg::CH_BSL);
					text_q.insert(text_q.size(), jsu_pkg::CH_U);
					repeat ($urandom_range(3))
						text_q.insert(text_q.size(), hex_char(4'($urandom)));
					do
						c = 8'($urandom);
					while (hex_nibble(c) >= 0);
					text_q.insert(text_q.size(), c);
					return;
				end
				default: begin
					v = pick_unit();
					put_u(v);
					if (v[15:10] == jsu_pkg::SUR_HIGH && $urandom_range(9) < 6)
						put_u(16'($urandom_range('hDFFF, 'hDC00)));
				end
			endcase
		end
		text_q.insert(text_q.size(), jsu_pkg::CH_QUOTE);
	endfunction

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_raw_bytes();
		text_q = {jsu_pkg::CH_QUOTE, 8'h00, 8'h7F, 8'h80, 8'hFF, "a", jsu_pkg::CH_QUOTE};
		send_text(text_q.size() - 1, 1'b1);
	endtask

	task automatic test_simple_escapes();
		send_str("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
	endtask

	task automatic test_unicode_escapes();
		send_str("\"\\u0000\\u007F\\u0080\\u07FF\\u0800\\uFFFF\\ud800\\uDC00\\uDBFF\\udfff\"",
			1'b0);
		// lone low surrogate
		send_str("\"\\uDC00\"", 1'b0);
	endtask

	task automatic test_surrogate_breaks();
		// held high surrogate followed by: plain text, a simple escape, a \u
		// escape that is no low surrogate, another high, then the closing quote
		send_str("\"\\uD800x\\uDBFF\\n\\uD800\\u0041\\uD800\\uDBFF\\uDFFF\\uDBFF\"", 1'b0);
	endtask

	task automatic test_errors();
		send_str("x", 1'b0);	// no opening quote
		send_str("\"\\q", 1'b0);
		send_str("\"\\u12G", 1'b0);
		send_str("\"\\uD800\\q", 1'b0);	// bad escape behind a held high
		send_str("\"ab", 1'b1);	// cut off mid body
		send_str("\"", 1'b1);	// ends on the opening quote
		send_str("\"\\uD800", 1'b1);	// ends with a high held
		send_str("\"\\z", 1'b1);	// bad escape beats truncation
		send_str("\"\"", 1'b1);
	endtask

	task automatic test_random_strings(input int count, input int gap_pct,
		input int stall_pct);
		int goal;
		logic [7:0] c;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		goal = n_sent + count;
		while (n_sent < goal) begin
			if ($urandom_range(19) == 0) begin
				// stray byte between strings
				do
					c = 8'($urandom);
				while (c == jsu_pkg::CH_QUOTE);
				text_q = {c};
				send_text(0, 1'($urandom_range(1)));
			end
			build_string();
			if (text_q.size() > 1 && $urandom_range(11) == 0)
				send_text($urandom_range(text_q.size() - 2), 1'b1);
			else
				send_text(text_q.size() - 1, $urandom_range(3) == 0);
		end
		wait_drained();
	endtask

	initial begin
		reset_decoder();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_raw_bytes();
		test_simple_escapes();
		test_unicode_escapes();
		test_surrogate_breaks();
		test_errors();
		wait_drained();

		test_random_strings(50, 0, 0);
		test_random_strings(50, 87, 0);
		test_random_strings(50, 0, 87);
		test_random_strings(50, 16, 16);
		test_random_strings(50, 0, 0);

		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
